>>> hdl/bb3_pkg.sv
// shared constants, types and register codes of the 3x3 box blur
package bb3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	// column index into the line stores, row count up to height + 1
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

	// raw register widths
	localparam int FW_W = 11;
	localparam int FH_W = 13;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

	localparam int W_RESET = 800;
	localparam int H_RESET = 600;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam logic [7:0] ALPHA = 8'hFF;

	// nine 8-bit samples
	localparam int SUM_W = 12;

	// floor(x / 9) == (x * 3641) >> 15 for x up to 9 * 255
	localparam logic [SUM_W-1:0] DIV9_MUL = 12'd3641;
	localparam int DIV9_SHIFT = 15;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} sum_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic sum_en;
	} cell_ctl_t;

endpackage

>>> hdl/bb3_pix_if.sv
// input pixel channel
interface bb3_pix_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

>>> hdl/bb3_res_if.sv
// blurred pixel result channel
interface bb3_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_word;
	logic        frame_last;

	modport source (output valid, pixel_word, frame_last, input ready);
	modport sink   (input valid, pixel_word, frame_last, output ready);
endinterface

>>> hdl/bb3_cfg_if.sv
// configuration register write channel
interface bb3_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bb3_pkg::CFG_IDX_W-1:0]  index;
	logic [bb3_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bb3_win_cell.sv
// one window column cell: holds three pixels, passes them on, gives its column sum
module bb3_win_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bb3_pkg::cell_ctl_t         ctl,
	input  bb3_pkg::rgb_t [2:0]        col_in,
	output bb3_pkg::rgb_t [2:0]        col_out,
	output bb3_pkg::sum_t              col_sum
);

	bb3_pkg::rgb_t [2:0] pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (ctl.clear) begin
			pix_q <= '0;
		end else if (ctl.load) begin
			pix_q <= col_in;
		end
	end

	assign col_out = pix_q;

	always_comb begin
		col_sum = '0;
		if (ctl.sum_en) begin
			col_sum.r = bb3_pkg::SUM_W'(pix_q[0].r) + bb3_pkg::SUM_W'(pix_q[1].r)
				+ bb3_pkg::SUM_W'(pix_q[2].r);
			col_sum.g = bb3_pkg::SUM_W'(pix_q[0].g) + bb3_pkg::SUM_W'(pix_q[1].g)
				+ bb3_pkg::SUM_W'(pix_q[2].g);
			col_sum.b = bb3_pkg::SUM_W'(pix_q[0].b) + bb3_pkg::SUM_W'(pix_q[1].b)
				+ bb3_pkg::SUM_W'(pix_q[2].b);
		end
	end

endmodule

>>> hdl/bb3_div9_pack.sv
// divide each channel sum by nine and pack as rgba
module bb3_div9_pack (
	input  bb3_pkg::sum_t sum,
	output logic [31:0]   word
);

	localparam int PROD_W = 2 * bb3_pkg::SUM_W;

	logic [PROD_W-1:0] prod_r;
	logic [PROD_W-1:0] prod_g;
	logic [PROD_W-1:0] prod_b;

	assign prod_r = PROD_W'(sum.r) * PROD_W'(bb3_pkg::DIV9_MUL);
	assign prod_g = PROD_W'(sum.g) * PROD_W'(bb3_pkg::DIV9_MUL);
	assign prod_b = PROD_W'(sum.b) * PROD_W'(bb3_pkg::DIV9_MUL);

	assign word = {
		prod_r[bb3_pkg::DIV9_SHIFT +: 8],
		prod_g[bb3_pkg::DIV9_SHIFT +: 8],
		prod_b[bb3_pkg::DIV9_SHIFT +: 8],
		bb3_pkg::ALPHA
	};

endmodule

>>> hdl/box_blur_3x3_rgb_unit.sv
// top level of the 3x3 rgb box blur
//
//  channel | dir  | fields                                    | accepted when
//  --------+------+-------------------------------------------+---------------------
//  pix     | in   | req_type, red_in, green_in, blue_in       | pix.valid & pix.ready
//  res     | out  | pixel_word, frame_last                    | res.valid & res.ready
//  cfg     | in   | index, data (0 frame_width, 1 frame_height)| cfg.valid & cfg.ready
//
// one item per clock sustained while the result side takes results; a taken item passes
// the line store read, window sum, and divide and pack into the output register
// arst_n clears counters, window cells, pipeline valids and sizes (800 x 600);
// line stores hold garbage until written and are only read where the row count allows
// each stage moves when the next one is empty or moving, so a stalled result only
// blocks input once the pipeline bubbles are filled
// a cfg write to frame_width or frame_height clears the frame position and the window; cfg.ready is always high
module box_blur_3x3_rgb_unit (
	input  logic           clk,
	input  logic           arst_n,
	bb3_pix_if.sink        pix,
	bb3_res_if.source      res,
	bb3_cfg_if.sink        cfg
);

	localparam int WW = bb3_pkg::COL_W + 1;
	localparam int RW = bb3_pkg::ROW_W;

	// per-item control carried from the counter stage to the window stage
	typedef struct packed {
		logic                      emit;
		logic                      last;
		logic                      use_old;
		logic                      use_new;
		logic                      top_ok;
		logic                      mid_ok;
		logic [bb3_pkg::COL_W-1:0] col;
	} item_ctl_t;

	function automatic logic [WW-1:0] clamp_w(input logic [bb3_pkg::FW_W-1:0] raw);
		logic [WW-1:0] res_w;
		if (raw == '0) begin
			res_w = WW'(1);
		end else if (int'(raw) > bb3_pkg::MAX_WIDTH) begin
			res_w = WW'(bb3_pkg::MAX_WIDTH);
		end else begin
			res_w = WW'(raw);
		end
		return res_w;
	endfunction

	function automatic logic [RW-1:0] clamp_h(input logic [bb3_pkg::FH_W-1:0] raw);
		logic [RW-1:0] res_h;
		if (raw == '0) begin
			res_h = RW'(1);
		end else if (int'(raw) > bb3_pkg::MAX_HEIGHT) begin
			res_h = RW'(bb3_pkg::MAX_HEIGHT);
		end else begin
			res_h = RW'(raw);
		end
		return res_h;
	endfunction

	// ---------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------
	logic [WW-1:0] w_q;
	logic [RW-1:0] h_q;
	logic          cfg_fire;
	logic          restart;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;
	assign restart   = cfg_fire & ((cfg.index == bb3_pkg::REG_FRAME_WIDTH)
		| (cfg.index == bb3_pkg::REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(bb3_pkg::W_RESET);
			h_q <= RW'(bb3_pkg::H_RESET);
		end else if (cfg_fire) begin
			case (cfg.index)
				bb3_pkg::REG_FRAME_WIDTH: begin
					w_q <= clamp_w(cfg.data[bb3_pkg::FW_W-1:0]);
				end
				bb3_pkg::REG_FRAME_HEIGHT: begin
					h_q <= clamp_h(cfg.data[bb3_pkg::FH_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// handshake between stages
	// ---------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic out_free;
	logic mv1;
	logic mv2;
	logic ready2;
	logic accept;

	assign out_free  = ~out_valid_q | res.ready;
	assign mv2       = valid_s2 & out_free;
	assign ready2    = ~valid_s2 | mv2;
	assign mv1       = valid_s1 & ready2;
	assign pix.ready = ~valid_s1 | mv1;
	assign accept    = pix.valid & pix.ready;

	// ---------------------------------------------------------------
	// stage 0: frame position, edge decisions, line store read
	// ---------------------------------------------------------------
	logic [bb3_pkg::COL_W-1:0] col_q;
	logic [RW-1:0]             row_q;
	logic                      c_zero;
	logic                      r_ge1;
	logic                      r_ge2;
	logic                      last0;
	logic [WW-1:0]             col_inc;
	item_ctl_t                 ctl0;
	bb3_pkg::rgb_t             bot0;

	assign c_zero  = (col_q == '0);
	assign r_ge1   = (row_q != '0);
	assign r_ge2   = (row_q >= RW'(2));
	assign last0   = c_zero & r_ge2 & (row_q == h_q + RW'(1));
	assign col_inc = WW'(col_q) + WW'(1);

	always_comb begin
		ctl0.emit    = c_zero ? r_ge2 : r_ge1;
		ctl0.last    = last0;
		// left neighbour column is outside the frame when the window is centred on column zero
		ctl0.use_old = c_zero ? (w_q >= WW'(2)) : (col_q >= bb3_pkg::COL_W'(2));
		// at column zero the window is centred on the last column of the row two above
		ctl0.use_new = ~c_zero;
		ctl0.top_ok  = r_ge2;
		ctl0.mid_ok  = r_ge1;
		ctl0.col     = col_q;
		// pixels after the frame rows, and drain items, enter as black
		if ((pix.req_type == bb3_pkg::REQ_PIXEL) && (row_q < h_q)) begin
			bot0 = '{r: pix.red_in, g: pix.green_in, b: pix.blue_in};
		end else begin
			bot0 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last0) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_q) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_inc[bb3_pkg::COL_W-1:0];
			end
		end
	end

	// line stores: one read at acceptance, one write when the item leaves stage 1
	bb3_pkg::rgb_t upper_mem [bb3_pkg::MAX_WIDTH];
	bb3_pkg::rgb_t lower_mem [bb3_pkg::MAX_WIDTH];
	bb3_pkg::rgb_t rd_upper_s1;
	bb3_pkg::rgb_t rd_lower_s1;
	bb3_pkg::rgb_t top_s1;
	bb3_pkg::rgb_t mid_s1;
	bb3_pkg::rgb_t bot_s1;
	item_ctl_t     ctl_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_upper_s1 <= upper_mem[col_q];
			rd_lower_s1 <= lower_mem[col_q];
		end
		if (mv1) begin
			upper_mem[ctl_s1.col] <= mid_s1;
			lower_mem[ctl_s1.col] <= bot_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: forward, window sum, window shift
	// ---------------------------------------------------------------
	logic          fwd_s1;
	bb3_pkg::rgb_t fwd_upper_s1;
	bb3_pkg::rgb_t fwd_lower_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
			// same entry written at this edge by the item ahead: its write beats the read
			fwd_s1   <= valid_s1 & (ctl_s1.col == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1       <= ctl0;
			bot_s1       <= bot0;
			fwd_upper_s1 <= mid_s1;
			fwd_lower_s1 <= bot_s1;
		end
	end

	always_comb begin
		top_s1 = '0;
		mid_s1 = '0;
		if (ctl_s1.top_ok) begin
			top_s1 = fwd_s1 ? fwd_upper_s1 : rd_upper_s1;
		end
		if (ctl_s1.mid_ok) begin
			mid_s1 = fwd_s1 ? fwd_lower_s1 : rd_lower_s1;
		end
	end

	// chain of two column cells: incoming column -> newer cell -> older cell
	bb3_pkg::rgb_t [2:0] in_col;
	bb3_pkg::rgb_t [2:0] newer_col;
	bb3_pkg::rgb_t [2:0] older_col;
	bb3_pkg::sum_t       newer_sum;
	bb3_pkg::sum_t       older_sum;
	bb3_pkg::sum_t       in_sum;
	bb3_pkg::sum_t       win_sum;
	bb3_pkg::cell_ctl_t  newer_ctl;
	bb3_pkg::cell_ctl_t  older_ctl;

	assign in_col = {bot_s1, mid_s1, top_s1};

	assign newer_ctl = '{load: mv1, clear: restart, sum_en: 1'b1};
	assign older_ctl = '{load: mv1, clear: restart, sum_en: ctl_s1.use_old};

	bb3_win_cell u_newer (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (newer_ctl),
		.col_in  (in_col),
		.col_out (newer_col),
		.col_sum (newer_sum)
	);

	bb3_win_cell u_older (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (older_ctl),
		.col_in  (newer_col),
		.col_out (older_col),
		.col_sum (older_sum)
	);

	always_comb begin
		in_sum = '0;
		if (ctl_s1.use_new) begin
			in_sum.r = bb3_pkg::SUM_W'(top_s1.r) + bb3_pkg::SUM_W'(mid_s1.r)
				+ bb3_pkg::SUM_W'(bot_s1.r);
			in_sum.g = bb3_pkg::SUM_W'(top_s1.g) + bb3_pkg::SUM_W'(mid_s1.g)
				+ bb3_pkg::SUM_W'(bot_s1.g);
			in_sum.b = bb3_pkg::SUM_W'(top_s1.b) + bb3_pkg::SUM_W'(mid_s1.b)
				+ bb3_pkg::SUM_W'(bot_s1.b);
		end
		win_sum.r = older_sum.r + newer_sum.r + in_sum.r;
		win_sum.g = older_sum.g + newer_sum.g + in_sum.g;
		win_sum.b = older_sum.b + newer_sum.b + in_sum.b;
	end

	// the older cell's contents leave the window here
	logic older_unused;
	assign older_unused = ^older_col;

	// ---------------------------------------------------------------
	// stage 2: registered sums, valid for emitting items only
	// ---------------------------------------------------------------
	bb3_pkg::sum_t sum_s2;
	logic          last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready2) begin
			valid_s2 <= mv1 & ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			sum_s2  <= win_sum;
			last_s2 <= ctl_s1.last;
		end
	end

	// ---------------------------------------------------------------
	// output register: divide by nine and pack
	// ---------------------------------------------------------------
	logic [31:0] word_s2;
	logic [31:0] out_word_q;
	logic        out_last_q;

	bb3_div9_pack u_div9 (
		.sum  (sum_s2),
		.word (word_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			out_word_q <= {word_s2[31:1], word_s2[0] | (older_unused & 1'b0)};
			out_last_q <= last_s2;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.pixel_word = out_word_q;
	assign res.frame_last = out_last_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(col_q) < w_q))
		else $error("column position beyond frame width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= h_q + RW'(1)))
		else $error("row position past the drain row");

	a_fwd_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1) |-> (ctl_s1.col == '0))
		else $error("line store forward outside column zero");

	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		mv2 |=> (res.valid && (res.pixel_word[7:0] == bb3_pkg::ALPHA)))
		else $error("moved result missing from output register");

endmodule

>>> tb/tb.sv
// testbench for the 3x3 rgb box blur: raster pixels in, rgba pixels checked by a predictor
`timescale 1ns / 1ps

module tb;

	localparam int BOX_AREA     = 9;     // pixels in the 3x3 neighborhood
	localparam int RANDOM_ITEMS = 260;   // size of the randomized part
	localparam int CFG_SETTLE   = 8;     // idle cycles after nothing is owed, before a size change
	localparam int END_SETTLE   = 20;    // quiet cycles at the end to catch stray results
	localparam int END_LIMIT    = 4000;  // cycles allowed for the last results
	localparam int MISS_PRINTS  = 10;

	typedef struct packed {
		logic          req;
		bb3_pkg::rgb_t px;
	} pix_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} blur_px_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bb3_pix_if pix ();
	bb3_res_if res ();
	bb3_cfg_if cfg ();

	box_blur_3x3_rgb_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// blur predictor: own copy of sizes, line stores, window and position
	// ---------------------------------------------------------------
	logic [bb3_pkg::FW_W-1:0] width_reg  = bb3_pkg::FW_W'(bb3_pkg::W_RESET);
	logic [bb3_pkg::FH_W-1:0] height_reg = bb3_pkg::FH_W'(bb3_pkg::H_RESET);
	bb3_pkg::rgb_t            upper_row [bb3_pkg::MAX_WIDTH];
	bb3_pkg::rgb_t            lower_row [bb3_pkg::MAX_WIDTH];
	bb3_pkg::rgb_t            win_col   [6] = '{default: '0};  // 0..2 older column, 3..5 newer
	int                       col_pos = 0;
	int                       row_pos = 0;

	pix_item_t pixel_queue [$];  // items waiting for the sender
	blur_px_t  blur_expect [$];  // blurred pixels still owed by the block

	int items_queued  = 0;
	int items_in      = 0;
	int pixels_seen   = 0;
	int frames_closed = 0;
	int sizes_used    = 0;
	int err_count     = 0;

	int send_gap   = 0;
	int send_calm  = 0;
	int recv_gap   = 0;
	int recv_calm  = 0;

	// zero acts as one, oversize clips to max_size
	function automatic int clamp_size(int raw, int max_size);
		if (raw == 0)
			return 1;
		if (raw > max_size)
			return max_size;
		return raw;
	endfunction

	function automatic bb3_pkg::sum_t add_rgb(bb3_pkg::sum_t s, bb3_pkg::rgb_t p);
		s.r = s.r + p.r;
		s.g = s.g + p.g;
		s.b = s.b + p.b;
		return s;
	endfunction

	// a size write always restarts the frame
	function automatic void set_register(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
			logic [bb3_pkg::CFG_DATA_W-1:0] val);
		if (idx == bb3_pkg::REG_FRAME_WIDTH)
			width_reg = val[bb3_pkg::FW_W-1:0];
		else if (idx == bb3_pkg::REG_FRAME_HEIGHT)
			height_reg = val[bb3_pkg::FH_W-1:0];
		else
			return;
		col_pos = 0;
		row_pos = 0;
		foreach (win_col[k])
			win_col[k] = '0;
	endfunction

	// one accepted item; returns 1 when it completes a blurred pixel
	function automatic bit blur_step(input logic req, input bb3_pkg::rgb_t px,
			output logic [31:0] word, output logic last);
		int            w, h, c, r, k;
		bb3_pkg::rgb_t top, mid, bot;
		bb3_pkg::sum_t acc;
		bit            emit;

		w    = clamp_size(int'(width_reg), bb3_pkg::MAX_WIDTH);
		h    = clamp_size(int'(height_reg), bb3_pkg::MAX_HEIGHT);
		c    = col_pos;
		r    = row_pos;
		acc  = '0;
		emit = 1'b0;
		last = 1'b0;
		word = '0;
		if (c >= w)
			c = w - 1;

		// drains, and pixels past the last row, enter as black
		bot = (req == bb3_pkg::REQ_PIXEL && r < h) ? px : '0;
		top = (r >= 2) ? upper_row[c] : '0;
		mid = (r >= 1) ? lower_row[c] : '0;
		upper_row[c] = mid;
		lower_row[c] = bot;

		if (c == 0) begin
			// wrap: finishes the rightmost pixel of the row two above
			if (r >= 2) begin
				emit = 1'b1;
				for (k = (w >= 2) ? 0 : 3; k < 6; k++)
					acc = add_rgb(acc, win_col[k]);
				last = (r == h + 1);
			end
		end else if (r >= 1) begin
			emit = 1'b1;
			for (k = (c >= 2) ? 0 : 3; k < 6; k++)
				acc = add_rgb(acc, win_col[k]);
			acc = add_rgb(add_rgb(add_rgb(acc, top), mid), bot);
		end

		for (k = 0; k < 3; k++)
			win_col[k] = win_col[k + 3];
		win_col[3] = top;
		win_col[4] = mid;
		win_col[5] = bot;

		if (last) begin
			col_pos = 0;
			row_pos = 0;
		end else begin
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			col_pos = c;
			row_pos = r;
		end

		if (emit)
			word = {8'(acc.r / BOX_AREA), 8'(acc.g / BOX_AREA), 8'(acc.b / BOX_AREA),
				bb3_pkg::ALPHA};
		return emit;
	endfunction

	// ---------------------------------------------------------------
	// helpers shared by both sides
	// ---------------------------------------------------------------

	// more than half the items go straight through, the rest draw a random wait that can be zero;
	// now and then a calm stretch with no waiting at all
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(16, 96);
			return 0;
		end
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	function automatic void log_miss(string what, logic [31:0] want, logic [31:0] got);
		err_count++;
		if (err_count <= MISS_PRINTS)
			$display("tb: mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
	endfunction

	// ---------------------------------------------------------------
	// sender: one item per handshake from the pending queue
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : sender
		pix_item_t nxt;
		if (!arst_n) begin
			pix.valid    <= 1'b0;
			pix.req_type <= bb3_pkg::REQ_PIXEL;
			pix.red_in   <= '0;
			pix.green_in <= '0;
			pix.blue_in  <= '0;
			send_gap     <= 0;
		end else if (!pix.valid || pix.ready) begin
			// the slot is free after this edge: gap, next item, or nothing
			if (send_gap != 0) begin
				pix.valid <= 1'b0;
				send_gap  <= send_gap - 1;
			end else if (pixel_queue.size() != 0) begin
				nxt = pixel_queue.pop_front();
				pix.valid    <= 1'b1;
				pix.req_type <= nxt.req;
				pix.red_in   <= nxt.px.r;
				pix.green_in <= nxt.px.g;
				pix.blue_in  <= nxt.px.b;
				send_gap     <= draw_wait(send_calm);
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: tracks size writes and accepted items, checks results,
	// and stalls the result side at random
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watcher
		bb3_pkg::rgb_t px_in;
		logic [31:0]   word;
		logic          last;
		blur_px_t      want;
		int            n;
		if (!arst_n) begin
			res.ready <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				set_register(cfg.index, cfg.data);

			if (pix.valid && pix.ready) begin
				items_in++;
				px_in = {pix.red_in, pix.green_in, pix.blue_in};
				if (blur_step(pix.req_type, px_in, word, last)) begin
					want.word = word;
					want.last = last;
					blur_expect.push_back(want);
				end
			end

			if (res.valid && res.ready) begin
				pixels_seen++;
				if (blur_expect.size() == 0) begin
					log_miss("pixel_word with nothing owed", '0, res.pixel_word);
				end else begin
					want = blur_expect.pop_front();
					if (want.last)
						frames_closed++;
					if (res.pixel_word !== want.word)
						log_miss("pixel_word", want.word, res.pixel_word);
					if (res.frame_last !== want.last)
						log_miss("frame_last", 32'(want.last), 32'(res.frame_last));
				end
				n = draw_wait(recv_calm);
				recv_gap  <= n;
				res.ready <= (n == 0);
			end else if (recv_gap > 1) begin
				recv_gap <= recv_gap - 1;
			end else begin
				recv_gap  <= 0;
				res.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	function automatic void push_item(logic req, bb3_pkg::rgb_t px);
		pix_item_t it;
		it.req = req;
		it.px  = px;
		pixel_queue.push_back(it);
		items_queued++;
	endfunction

	// content styles: random, saturated channels, black, near the rails
	function automatic bb3_pkg::rgb_t make_pixel(int style);
		bb3_pkg::rgb_t p;
		case (style)
			1: begin
				p.r = {8{1'($urandom_range(0, 1))}};
				p.g = {8{1'($urandom_range(0, 1))}};
				p.b = {8{1'($urandom_range(0, 1))}};
			end
			2: p = '0;
			3: begin
				p.r = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(252, 255))
					: 8'($urandom_range(0, 3));
				p.g = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(252, 255))
					: 8'($urandom_range(0, 3));
				p.b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(252, 255))
					: 8'($urandom_range(0, 3));
			end
			default: p = 24'($urandom);
		endcase
		return p;
	endfunction

	// no item pending or in flight on the input, nothing owed
	task automatic wait_idle(int settle);
		while (pixel_queue.size() != 0 || pix.valid || blur_expect.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= bb3_pkg::CFG_DATA_W'(value);
		forever begin
			@(posedge clk);
			if (cfg.ready)
				break;
		end
		cfg.valid <= 1'b0;
	endtask

	// sizes change only with the block empty, items without a result included
	task automatic set_size(int w_raw, int h_raw);
		wait_idle(CFG_SETTLE);
		if ($urandom_range(0, 1) != 0) begin
			write_reg(bb3_pkg::REG_FRAME_WIDTH, w_raw);
			write_reg(bb3_pkg::REG_FRAME_HEIGHT, h_raw);
		end else begin
			write_reg(bb3_pkg::REG_FRAME_HEIGHT, h_raw);
			write_reg(bb3_pkg::REG_FRAME_WIDTH, w_raw);
		end
		sizes_used++;
	endtask

	// one frame of w x h pixels plus w + 1 trailing items; stops early at
	// stop_at, and with hold_mid the sender sits idle halfway until every
	// owed pixel is back
	task automatic queue_frame(int w, int h, int style, int stop_at, bit hold_mid);
		int total, k;
		total = w * h + w + 1;
		for (k = 0; k < total && k < stop_at; k++) begin
			if (hold_mid && k == total / 2)
				wait_idle(0);
			if (k < w * h) begin
				// an occasional drain inside the frame reads as black
				if ($urandom_range(0, 29) == 0)
					push_item(bb3_pkg::REQ_DRAIN, make_pixel(0));
				else
					push_item(bb3_pkg::REQ_PIXEL, make_pixel(style));
			end else begin
				// past the last row an image pixel only flushes, like a drain
				if ($urandom_range(0, 4) == 0)
					push_item(bb3_pkg::REQ_PIXEL, make_pixel(0));
				else
					push_item(bb3_pkg::REQ_DRAIN, make_pixel(0));
			end
		end
	endtask

	initial begin : stimulus
		int w_raw, h_raw, frames, f, cut, mark, i;
		bit first;

		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data  = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset size 800 x 600: a row and a bit, enough for the first blurred pixels
		queue_frame(bb3_pkg::W_RESET, bb3_pkg::H_RESET, 0, bb3_pkg::W_RESET + 21, 1'b0);

		// 3x3 frame: saturated and black pixels, a drain in the middle row,
		// and image pixels in the flush that must not leak in
		set_size(3, 3);
		push_item(bb3_pkg::REQ_PIXEL, 24'hFFFFFF);
		push_item(bb3_pkg::REQ_PIXEL, 24'hFFFFFF);
		push_item(bb3_pkg::REQ_PIXEL, 24'h000000);
		push_item(bb3_pkg::REQ_DRAIN, 24'hFFFFFF);
		push_item(bb3_pkg::REQ_PIXEL, 24'h807F01);
		push_item(bb3_pkg::REQ_PIXEL, 24'hFF00FF);
		push_item(bb3_pkg::REQ_PIXEL, 24'h000000);
		push_item(bb3_pkg::REQ_PIXEL, 24'h000000);
		push_item(bb3_pkg::REQ_PIXEL, 24'h010203);
		push_item(bb3_pkg::REQ_PIXEL, 24'hAA55AA);
		push_item(bb3_pkg::REQ_DRAIN, 24'h000000);
		push_item(bb3_pkg::REQ_DRAIN, 24'hFFFFFF);
		push_item(bb3_pkg::REQ_PIXEL, 24'h123456);

		// zero sizes act as 1 x 1: an all-black neighborhood, then one with a white centre
		set_size(0, 0);
		push_item(bb3_pkg::REQ_PIXEL, 24'h000000);
		push_item(bb3_pkg::REQ_DRAIN, 24'h000000);
		push_item(bb3_pkg::REQ_DRAIN, 24'h000000);
		push_item(bb3_pkg::REQ_PIXEL, 24'hFFFFFF);
		push_item(bb3_pkg::REQ_PIXEL, 24'h00FF00);
		push_item(bb3_pkg::REQ_DRAIN, 24'h000000);

		// random part: mostly small complete frames, a few cut short, and
		// now and then an odd size including zero
		mark  = items_queued;
		first = 1'b1;
		while (items_queued - mark < RANDOM_ITEMS) begin
			w_raw  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
			h_raw  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
			set_size(w_raw, h_raw);
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				// only the last frame of a setting may be cut, the size write restarts it
				if (f == frames - 1 && $urandom_range(0, 5) == 0)
					cut = $urandom_range(1, clamp_size(w_raw, bb3_pkg::MAX_WIDTH)
						* (clamp_size(h_raw, bb3_pkg::MAX_HEIGHT) + 1));
				else
					cut = 32'h7FFF_FFFF;
				queue_frame(clamp_size(w_raw, bb3_pkg::MAX_WIDTH),
					clamp_size(h_raw, bb3_pkg::MAX_HEIGHT),
					$urandom_range(0, 3), cut, first || $urandom_range(0, 9) == 0);
				first = 1'b0;
			end
		end

		// wind down: everything sent, owed pixels back, then a quiet spell
		while (pixel_queue.size() != 0 || pix.valid)
			@(posedge clk);
		for (i = 0; i < END_LIMIT && blur_expect.size() != 0; i++)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);
		if (blur_expect.size() != 0) begin
			$display("tb: %0d blurred pixels never came out", blur_expect.size());
			err_count += blur_expect.size();
		end

		$display("tb: %0d items over %0d size settings, %0d blurred pixels compared",
			items_in, sizes_used, pixels_seen);
		$display("tb: %0d frames closed, %0d mismatches", frames_closed, err_count);
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// stop a hung run
	initial begin : watchdog
		#30_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
